// ===== design/e2c_pkg.sv =====
// package for the epoch seconds to calendar converter
// item types, sequencer states, time constants and month tables; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package e2c_pkg;

  // widths of the item fields
  localparam int unsigned EpochW  = 33;
  localparam int unsigned RemW    = 32;
  localparam int unsigned StepW   = 25;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned NameW   = 24;

  // time constants in seconds
  localparam logic [StepW-1:0] SecCommonYear = 25'd31536000;
  localparam logic [StepW-1:0] SecLeapYear   = 25'd31622400;
  localparam logic [StepW-1:0] SecDay        = 25'd86400;
  localparam logic [StepW-1:0] SecHour       = 25'd3600;
  localparam logic [StepW-1:0] SecMinute     = 25'd60;
  localparam logic [EpochW-1:0] LastValidSec = 33'd4102444799;
  localparam logic [YearW-1:0] EpochYear     = 12'd1970;
  localparam logic [YearW-1:0] LastYear      = 12'd2099;
  localparam logic [MonthW-1:0] LastMonthIdx = 4'd11;

  // input item
  typedef struct packed {
    logic [EpochW-1:0] epoch_seconds;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic [NameW-1:0]   month_name;
    logic               range_error;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_DONE
  } state_e;

  // seconds in a month, zero-based month index
  function automatic logic [StepW-1:0] month_secs(input logic [MonthW-1:0] idx,
                                                  input logic leap);
    logic [StepW-1:0] secs;
    begin
      case (idx)
        4'd1:                     secs = leap ? 25'd2505600 : 25'd2419200;
        4'd3, 4'd5, 4'd8, 4'd10:  secs = 25'd2592000;
        default:                  secs = 25'd2678400;
      endcase
      return secs;
    end
  endfunction

  // packed ascii month name, first letter on top
  function automatic logic [NameW-1:0] month_name(input logic [MonthW-1:0] idx);
    logic [NameW-1:0] name;
    begin
      case (idx)
        4'd0:    name = "JAN";
        4'd1:    name = "FEB";
        4'd2:    name = "MAR";
        4'd3:    name = "APR";
        4'd4:    name = "MAY";
        4'd5:    name = "JUN";
        4'd6:    name = "JUL";
        4'd7:    name = "AUG";
        4'd8:    name = "SEP";
        4'd9:    name = "OCT";
        4'd10:   name = "NOV";
        4'd11:   name = "DEC";
        default: name = '0;
      endcase
      return name;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/e2c_if.sv =====
// valid/ready channel interfaces for input and result items
// depends on e2c_pkg for the item types
`timescale 1ns / 1ps
`default_nettype none

interface e2c_in_if;
  logic               valid;
  logic               ready;
  e2c_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface e2c_out_if;
  logic               valid;
  logic               ready;
  e2c_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/epoch_seconds_to_calendar.sv =====
// epoch seconds to calendar date: an in-range item walks the years, months, days,
// hours and minutes in turn, up to 2099-12-31 23:59:59; an out-of-range item goes
// straight to the result state and is delivered as zeros with range_error set.
// one item at a time: a single shared compare-and-subtract unit walks the years,
// months, days, hours and minutes. the result register lets the next item in while
// a result waits. async active-low reset clears the sequencer and result valid.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire            clk_i,
  input  wire            rst_ni,
  e2c_in_if.sink         in_i,
  e2c_out_if.source      out_o
);

  e2c_pkg::state_e state_q, state_d;

  logic [e2c_pkg::RemW-1:0]    rem_q, rem_d;
  logic [e2c_pkg::YearW-1:0]   year_q, year_d;
  logic [e2c_pkg::MonthW-1:0]  mon_idx_q, mon_idx_d;
  logic [e2c_pkg::DayW-1:0]    day_q, day_d;
  logic [e2c_pkg::HourW-1:0]   hour_q, hour_d;
  logic [e2c_pkg::MinuteW-1:0] min_q, min_d;
  logic                        err_q, err_d;

  logic                 out_valid_q, out_valid_d;
  e2c_pkg::out_item_t   out_data_q, out_data_d;

  logic [e2c_pkg::StepW-1:0] step;
  logic [e2c_pkg::RemW:0]    diff;
  logic                      take;
  logic                      leap;
  logic                      accept;
  logic                      load_out;

  assign leap     = (year_q[1:0] == 2'b00);
  assign accept   = in_i.valid && in_i.ready;
  assign load_out = (state_q == e2c_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  // shared compare-and-subtract unit, step picked by the state
  always_comb begin
    case (state_q)
      e2c_pkg::ST_YEAR:  step = leap ? e2c_pkg::SecLeapYear : e2c_pkg::SecCommonYear;
      e2c_pkg::ST_MONTH: step = e2c_pkg::month_secs(mon_idx_q, leap);
      e2c_pkg::ST_DAY:   step = e2c_pkg::SecDay;
      e2c_pkg::ST_HOUR:  step = e2c_pkg::SecHour;
      default:           step = e2c_pkg::SecMinute;
    endcase
    diff = {1'b0, rem_q} - {{(e2c_pkg::RemW + 1 - e2c_pkg::StepW){1'b0}}, step};
    take = !diff[e2c_pkg::RemW];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      e2c_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.data.epoch_seconds > e2c_pkg::LastValidSec) ?
                    e2c_pkg::ST_DONE : e2c_pkg::ST_YEAR;
        end
      end
      e2c_pkg::ST_YEAR:  if (!take) state_d = e2c_pkg::ST_MONTH;
      e2c_pkg::ST_MONTH: begin
        if (!take || mon_idx_q == e2c_pkg::LastMonthIdx) state_d = e2c_pkg::ST_DAY;
      end
      e2c_pkg::ST_DAY:   if (!take) state_d = e2c_pkg::ST_HOUR;
      e2c_pkg::ST_HOUR:  if (!take) state_d = e2c_pkg::ST_MIN;
      e2c_pkg::ST_MIN:   if (!take) state_d = e2c_pkg::ST_DONE;
      e2c_pkg::ST_DONE:  if (load_out) state_d = e2c_pkg::ST_IDLE;
      default:           state_d = e2c_pkg::ST_IDLE;
    endcase
  end

  // datapath and result register updates
  always_comb begin
    rem_d       = rem_q;
    year_d      = year_q;
    mon_idx_d   = mon_idx_q;
    day_d       = day_q;
    hour_d      = hour_q;
    min_d       = min_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      e2c_pkg::ST_IDLE: begin
        if (accept) begin
          rem_d     = in_i.data.epoch_seconds[e2c_pkg::RemW-1:0];
          err_d     = (in_i.data.epoch_seconds > e2c_pkg::LastValidSec);
          year_d    = e2c_pkg::EpochYear;
          mon_idx_d = '0;
          day_d     = '0;
          hour_d    = '0;
          min_d     = '0;
        end
      end
      e2c_pkg::ST_YEAR: begin
        if (take) begin
          rem_d  = diff[e2c_pkg::RemW-1:0];
          year_d = year_q + 1'b1;
        end
      end
      e2c_pkg::ST_MONTH: begin
        if (take && mon_idx_q != e2c_pkg::LastMonthIdx) begin
          rem_d     = diff[e2c_pkg::RemW-1:0];
          mon_idx_d = mon_idx_q + 1'b1;
        end
      end
      e2c_pkg::ST_DAY: begin
        if (take) begin
          rem_d = diff[e2c_pkg::RemW-1:0];
          day_d = day_q + 1'b1;
        end
      end
      e2c_pkg::ST_HOUR: begin
        if (take) begin
          rem_d  = diff[e2c_pkg::RemW-1:0];
          hour_d = hour_q + 1'b1;
        end
      end
      e2c_pkg::ST_MIN: begin
        if (take) begin
          rem_d = diff[e2c_pkg::RemW-1:0];
          min_d = min_q + 1'b1;
        end
      end
      e2c_pkg::ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_data_d             = '0;
            out_data_d.range_error = 1'b1;
          end else begin
            out_data_d.year        = year_q;
            out_data_d.month       = mon_idx_q + 1'b1;
            out_data_d.day         = day_q + 1'b1;
            out_data_d.hour        = hour_q;
            out_data_d.minute      = min_q;
            out_data_d.second      = rem_q[e2c_pkg::SecondW-1:0];
            out_data_d.month_name  = e2c_pkg::month_name(mon_idx_q);
            out_data_d.range_error = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= e2c_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    year_q     <= year_d;
    mon_idx_q  <= mon_idx_d;
    day_q      <= day_d;
    hour_q     <= hour_d;
    min_q      <= min_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
  end

  // ports
  assign in_i.ready  = (state_q == e2c_pkg::ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTHESIS
  // an in-range item starts the year walk
  a_start_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.data.epoch_seconds <= e2c_pkg::LastValidSec)
    |=> state_q == e2c_pkg::ST_YEAR)
    else $error("in-range item did not start the year walk");

  // month counter never passes december
  a_month_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == e2c_pkg::ST_MONTH) |-> (mon_idx_q <= e2c_pkg::LastMonthIdx))
    else $error("month index out of range");

  // day walk starts below one month of seconds
  a_day_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == e2c_pkg::ST_DAY) && $past(state_q == e2c_pkg::ST_MONTH)
    |-> (rem_q < 32'd2678400))
    else $error("remainder too large after month walk");

  // delivered year stays within the supported span
  a_year_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.range_error
    |-> (out_data_q.year >= e2c_pkg::EpochYear) && (out_data_q.year <= e2c_pkg::LastYear))
    else $error("result year out of span");
`endif

endmodule

`default_nettype wire
